>>> sv/mfhs_pkg.sv
package mfhs_pkg;

	// one scan outcome handed from the front to the back
	typedef struct packed {
		logic        found;
		logic [31:0] hdr;
		logic [23:0] offset;
	} scan_event_t;

	localparam logic [7:0] SYNC_BYTE   = 8'hFF;
	localparam logic [3:0] SYNC_NIBBLE = 4'hF;

	localparam logic [1:0] BR_VALID = 2'd0;
	localparam logic [1:0] BR_FREE  = 2'd1;
	localparam logic [1:0] BR_BAD   = 2'd2;

	localparam logic [3:0] BR_IDX_FREE = 4'd0;
	localparam logic [3:0] BR_IDX_BAD  = 4'd15;
	localparam logic [1:0] SR_RESERVED = 2'd3;
	localparam logic [1:0] LAYER_III   = 2'b01;

	function automatic logic [8:0] l3_kbps(input logic [3:0] idx);
		logic [8:0] r;
		case (idx)
			4'd1:    r = 9'd32;
			4'd2:    r = 9'd40;
			4'd3:    r = 9'd48;
			4'd4:    r = 9'd56;
			4'd5:    r = 9'd64;
			4'd6:    r = 9'd80;
			4'd7:    r = 9'd96;
			4'd8:    r = 9'd112;
			4'd9:    r = 9'd128;
			4'd10:   r = 9'd160;
			4'd11:   r = 9'd192;
			4'd12:   r = 9'd224;
			4'd13:   r = 9'd256;
			4'd14:   r = 9'd320;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] mpeg1_hz(input logic [1:0] code);
		logic [15:0] r;
		case (code)
			2'd0:    r = 16'd44100;
			2'd1:    r = 16'd48000;
			2'd2:    r = 16'd32000;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

endpackage

>>> sv/mfhs_front.sv
module mfhs_front import mfhs_pkg::*; #(
	parameter int OFFSET_BITS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_take,
	input  logic [7:0]        byte_value,
	input  logic              last_byte,
	output logic              ev_push,
	output scan_event_t       ev_data
);

	typedef enum logic [1:0] {
		HUNT,
		CAPT,
		DONE
	} phase_t;

	phase_t                 phase_q;
	logic [1:0]             cnt_q;
	logic [23:0]            shift_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [OFFSET_BITS-1:0] sync_q;
	logic [OFFSET_BITS+23:0] sync_ext;
	logic                   emit_found;
	logic                   emit_none;

	assign sync_ext   = {24'd0, sync_q};
	assign emit_found = in_take && (phase_q == CAPT) && (cnt_q == 2'd3);
	// stream ended before a full header, unless one was already reported
	assign emit_none  = in_take && last_byte && !emit_found &&
		(phase_q == HUNT || phase_q == CAPT);

	assign ev_push = emit_found || emit_none;
	always_comb begin
		ev_data.found  = emit_found;
		ev_data.hdr    = emit_found ? {shift_q, byte_value} : 32'd0;
		ev_data.offset = emit_found ? sync_ext[23:0] : 24'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= HUNT;
			cnt_q   <= 2'd0;
			shift_q <= 24'd0;
			pos_q   <= '0;
			sync_q  <= '0;
		end else if (in_take) begin
			if (last_byte) begin
				phase_q <= HUNT;
				cnt_q   <= 2'd0;
				shift_q <= 24'd0;
				pos_q   <= '0;
				sync_q  <= '0;
			end else begin
				if (pos_q != '1) begin
					pos_q <= pos_q + 1'b1;
				end
				case (phase_q)
					HUNT: begin
						if (cnt_q == 2'd0) begin
							if (byte_value == SYNC_BYTE) begin
								shift_q <= {16'd0, SYNC_BYTE};
								cnt_q   <= 2'd1;
								sync_q  <= pos_q;
							end
						end else if (byte_value[7:4] == SYNC_NIBBLE) begin
							shift_q <= {shift_q[15:0], byte_value};
							cnt_q   <= 2'd2;
							phase_q <= CAPT;
						end else begin
							cnt_q   <= 2'd0;
							shift_q <= 24'd0;
						end
					end
					CAPT: begin
						if (cnt_q == 2'd2) begin
							shift_q <= {shift_q[15:0], byte_value};
							cnt_q   <= 2'd3;
						end else begin
							phase_q <= DONE;
						end
					end
					default: begin
						phase_q <= phase_q;
					end
				endcase
			end
		end
	end

endmodule

>>> sv/mfhs_queue.sv
module mfhs_queue import mfhs_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  scan_event_t wr_data,
	output logic        is_full,
	input  logic        rd_en,
	output logic        has_data,
	output scan_event_t rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	scan_event_t    mem_q [DEPTH];
	logic [PW-1:0]  wp_q;
	logic [PW-1:0]  rp_q;
	logic [CW-1:0]  cnt_q;
	logic           do_wr;
	logic           do_rd;

	assign is_full  = (cnt_q == CW'(DEPTH));
	assign has_data = (cnt_q != '0);
	assign do_wr    = wr_en && !is_full;
	assign do_rd    = rd_en && has_data;
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> sv/mfhs_back.sv
module mfhs_back import mfhs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ev_avail,
	input  scan_event_t ev_data,
	output logic        ev_take,
	output logic        empty,
	input  logic        pop,
	output logic        header_found,
	output logic [23:0] sync_offset,
	output logic        is_mpeg1_layer3,
	output logic [8:0]  bitrate_kbps,
	output logic [1:0]  bitrate_status,
	output logic [15:0] sample_rate_hz,
	output logic        rate_reserved,
	output logic        copyrighted,
	output logic        original_media
);

	logic       valid_q;
	logic [3:0] br_idx;
	logic [1:0] sr_code;
	logic       f;

	assign br_idx  = ev_data.hdr[15:12];
	assign sr_code = ev_data.hdr[11:10];
	assign f       = ev_data.found;
	assign ev_take = ev_avail && (!valid_q || pop);
	assign empty   = !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ev_take) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	// not-found beats carry all-zero fields
	always_ff @(posedge clk) begin
		if (ev_take) begin
			header_found    <= f;
			sync_offset     <= ev_data.offset;
			is_mpeg1_layer3 <= f && ev_data.hdr[19] && (ev_data.hdr[18:17] == LAYER_III);
			bitrate_kbps    <= f ? l3_kbps(br_idx) : 9'd0;
			if (!f) begin
				bitrate_status <= BR_VALID;
			end else if (br_idx == BR_IDX_FREE) begin
				bitrate_status <= BR_FREE;
			end else if (br_idx == BR_IDX_BAD) begin
				bitrate_status <= BR_BAD;
			end else begin
				bitrate_status <= BR_VALID;
			end
			sample_rate_hz  <= f ? mpeg1_hz(sr_code) : 16'd0;
			rate_reserved   <= f && (sr_code == SR_RESERVED);
			copyrighted     <= f && ev_data.hdr[3];
			original_media  <= f && ev_data.hdr[2];
		end
	end

endmodule

>>> sv/mp3_frame_header_scanner.sv
// mp3 frame header scanner
// input side: one stream byte per beat on byte_value, with last_byte marking
//   the final byte of a stream; a beat is taken when push is high and full low
// output side: a queue view; while empty is low the oldest result sits on the
//   result ports, and pop with empty low takes it
// the front scans for the first sync (0xff then a byte with top nibble 0xf),
//   collects four header bytes and hands one event to a small event queue;
//   later bytes are skipped until last_byte re-arms the scan
// a stream that ends without a full header yields a beat with header_found
//   low and every other field zero
// the back decodes the queue head into the output register
// throughput: one byte per cycle while full is low, set by the scan state machine
// result path: with the output free, the event for the completing byte is written
//   into the event queue as the byte is taken, then the output register loads it
// stall: a held output fills the event queue; full rises only once it is
//   full, and since at most one event comes per byte the scan keeps taking
//   bytes until then
// reset: scan state, positions, event queue and output valid flag all clear
module mp3_frame_header_scanner import mfhs_pkg::*; #(
	parameter int OFFSET_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  byte_value,
	input  logic        last_byte,
	output logic        empty,
	input  logic        pop,
	output logic        header_found,
	output logic [23:0] sync_offset,
	output logic        is_mpeg1_layer3,
	output logic [8:0]  bitrate_kbps,
	output logic [1:0]  bitrate_status,
	output logic [15:0] sample_rate_hz,
	output logic        rate_reserved,
	output logic        copyrighted,
	output logic        original_media
);

	logic        in_take;
	logic        ev_push;
	scan_event_t ev_in;
	logic        q_full;
	logic        q_avail;
	logic        q_take;
	scan_event_t q_head;

	// the front never emits more than one event per byte, so a free queue
	// slot is all it needs to take the next byte
	assign full    = q_full;
	assign in_take = push && !q_full;

	mfhs_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_take   (in_take),
		.byte_value(byte_value),
		.last_byte (last_byte),
		.ev_push   (ev_push),
		.ev_data   (ev_in)
	);

	mfhs_queue #(
		.DEPTH(4)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (ev_push),
		.wr_data (ev_in),
		.is_full (q_full),
		.rd_en   (q_take),
		.has_data(q_avail),
		.rd_data (q_head)
	);

	mfhs_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.ev_avail       (q_avail),
		.ev_data        (q_head),
		.ev_take        (q_take),
		.empty          (empty),
		.pop            (pop),
		.header_found   (header_found),
		.sync_offset    (sync_offset),
		.is_mpeg1_layer3(is_mpeg1_layer3),
		.bitrate_kbps   (bitrate_kbps),
		.bitrate_status (bitrate_status),
		.sample_rate_hz (sample_rate_hz),
		.rate_reserved  (rate_reserved),
		.copyrighted    (copyrighted),
		.original_media (original_media)
	);

endmodule

>>> test/tb_top.sv
module tb_top import mfhs_pkg::*; ();

	// one decoded header beat, laid out in port order
	typedef struct packed {
		logic        found;
		logic [23:0] offset;
		logic        l3;
		logic [8:0]  kbps;
		logic [1:0]  br_status;
		logic [15:0] hz;
		logic        rsv;
		logic        copy_bit;
		logic        orig_bit;
	} hdr_result_t;

	// one directed stream byte; want is used only where typed is set
	typedef struct {
		logic [7:0]  b;
		logic        lst;
		bit          typed;
		hdr_result_t want;
	} stim_row_t;

	typedef enum logic [1:0] {
		SCAN_HUNT,
		SCAN_CAPTURE,
		SCAN_DONE
	} scan_phase_e;

	localparam hdr_result_t NO_RESULT = '0;
	localparam int DIRECTED_ROWS = 25;
	localparam int RANDOM_ITEMS  = 650;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  byte_value;
	logic        last_byte;
	logic        empty;
	logic        pop;
	logic        header_found;
	logic [23:0] sync_offset;
	logic        is_mpeg1_layer3;
	logic [8:0]  bitrate_kbps;
	logic [1:0]  bitrate_status;
	logic [15:0] sample_rate_hz;
	logic        rate_reserved;
	logic        copyrighted;
	logic        original_media;

	// layer iii bitrate per index and mpeg-1 sample rate per code
	logic [8:0]  kbps_l3 [16] = '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
		9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
	logic [15:0] rate_hz [4] = '{16'd44100, 16'd48000, 16'd32000, 16'd0};

	// scanner state as the predictor sees it
	scan_phase_e phase;
	logic [23:0] shift;
	logic [1:0]  held;
	logic [23:0] pos;
	logic [23:0] sync_pos;

	hdr_result_t pending_results[$];
	int          mismatch_count = 0;

	// idle pattern of each side: runs of beats with or without random waits
	int tx_run = 0;
	bit tx_calm = 0;
	int rx_run = 0;
	bit rx_calm = 0;

	stim_row_t dir_tab [DIRECTED_ROWS];

	mp3_frame_header_scanner i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.byte_value      (byte_value),
		.last_byte       (last_byte),
		.empty           (empty),
		.pop             (pop),
		.header_found    (header_found),
		.sync_offset     (sync_offset),
		.is_mpeg1_layer3 (is_mpeg1_layer3),
		.bitrate_kbps    (bitrate_kbps),
		.bitrate_status  (bitrate_status),
		.sample_rate_hz  (sample_rate_hz),
		.rate_reserved   (rate_reserved),
		.copyrighted     (copyrighted),
		.original_media  (original_media)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// inputs known from time zero, reset held low until the stimulus releases it
	initial begin
		arst_n     = 1'b0;
		push       = 1'b0;
		pop        = 1'b0;
		byte_value = '0;
		last_byte  = 1'b0;
	end

	// hard stop in case a handshake never completes
	initial begin
		#3000000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic void clear_scan();
		phase    = SCAN_HUNT;
		shift    = '0;
		held     = '0;
		pos      = '0;
		sync_pos = '0;
	endfunction

	// decode the 32-bit header word, first byte in the top bits
	function automatic hdr_result_t decode_header(input logic [31:0] h);
		hdr_result_t r;
		logic [3:0]  bi;
		logic [1:0]  fi;
		bi = h[15:12];
		fi = h[11:10];
		r.found     = 1'b1;
		r.offset    = sync_pos;
		r.l3        = h[19] && (h[18:17] == LAYER_III);
		r.kbps      = kbps_l3[bi];
		r.br_status = (bi == BR_IDX_FREE) ? BR_FREE : (bi == BR_IDX_BAD) ? BR_BAD : BR_VALID;
		r.hz        = rate_hz[fi];
		r.rsv       = (fi == SR_RESERVED);
		r.copy_bit  = h[3];
		r.orig_bit  = h[2];
		return r;
	endfunction

	// advance the scanner by one accepted byte; returns 1 when a beat is due
	function automatic bit predict_scan(input logic [7:0] b, input logic lst,
			output hdr_result_t r);
		bit made;
		made = 1'b0;
		r    = NO_RESULT;
		case (phase)
			SCAN_HUNT: begin
				if (held == 2'd0) begin
					if (b == SYNC_BYTE) begin
						shift    = {16'd0, SYNC_BYTE};
						held     = 2'd1;
						sync_pos = pos;
					end
				end else if (b[7:4] == SYNC_NIBBLE) begin
					// an ff here also counts as the second sync byte
					shift = {shift[15:0], b};
					held  = 2'd2;
					phase = SCAN_CAPTURE;
				end else begin
					held  = 2'd0;
					shift = '0;
				end
			end
			SCAN_CAPTURE: begin
				if (held == 2'd2) begin
					shift = {shift[15:0], b};
					held  = 2'd3;
				end else begin
					r     = decode_header({shift, b});
					made  = 1'b1;
					phase = SCAN_DONE;
				end
			end
			default: ;
		endcase
		if (pos != '1)
			pos = pos + 24'd1;
		if (lst) begin
			// stream ended short of a header: all-zero not-found beat
			if (!made && phase != SCAN_DONE)
				made = 1'b1;
			clear_scan();
		end
		return made;
	endfunction

	function automatic int draw_wait(inout int run_left, inout bit calm);
		if (run_left == 0) begin
			run_left = $urandom_range(8, 40);
			calm     = ($urandom_range(0, 3) == 0);
		end
		run_left--;
		return calm ? 0 : $urandom_range(0, 14);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// push one byte; the expected beat is taken from the row when typed,
	// otherwise from the predictor
	task automatic send_byte(input logic [7:0] b, input logic lst, input bit typed,
			input hdr_result_t want);
		hdr_result_t pred;
		bit          made;
		int          gap;
		gap = draw_wait(tx_run, tx_calm);
		repeat (gap) @(negedge clk);
		push       = 1'b1;
		byte_value = b;
		last_byte  = lst;
		@(posedge clk);
		while (full) @(posedge clk);
		made = predict_scan(b, lst, pred);
		if (typed)
			pending_results.push_back(want);
		else if (made)
			pending_results.push_back(pred);
		@(negedge clk);
		// idle bus carries junk that must be ignored
		push       = 1'b0;
		byte_value = 8'($urandom);
		last_byte  = 1'($urandom);
	endtask

	// noise biased toward sync-looking bytes to provoke false starts
	function automatic logic [7:0] noise_byte();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 2)
			return SYNC_BYTE;
		if (sel == 2)
			return {SYNC_NIBBLE, 4'($urandom)};
		return 8'($urandom);
	endfunction

	// compare an accepted result beat with the oldest expectation
	task automatic check_beat();
		hdr_result_t w;
		if (pending_results.size() == 0) begin
			report_mismatch("result beat with nothing expected");
			return;
		end
		w = pending_results.pop_front();
		if (header_found !== w.found)
			report_mismatch($sformatf("header_found %0b, want %0b", header_found, w.found));
		if (sync_offset !== w.offset)
			report_mismatch($sformatf("sync_offset %0d, want %0d", sync_offset, w.offset));
		if (is_mpeg1_layer3 !== w.l3)
			report_mismatch($sformatf("is_mpeg1_layer3 %0b, want %0b", is_mpeg1_layer3, w.l3));
		if (bitrate_kbps !== w.kbps)
			report_mismatch($sformatf("bitrate_kbps %0d, want %0d", bitrate_kbps, w.kbps));
		if (bitrate_status !== w.br_status)
			report_mismatch($sformatf("bitrate_status %0d, want %0d", bitrate_status,
				w.br_status));
		if (sample_rate_hz !== w.hz)
			report_mismatch($sformatf("sample_rate_hz %0d, want %0d", sample_rate_hz, w.hz));
		if (rate_reserved !== w.rsv)
			report_mismatch($sformatf("rate_reserved %0b, want %0b", rate_reserved, w.rsv));
		if (copyrighted !== w.copy_bit)
			report_mismatch($sformatf("copyrighted %0b, want %0b", copyrighted, w.copy_bit));
		if (original_media !== w.orig_bit)
			report_mismatch($sformatf("original_media %0b, want %0b", original_media,
				w.orig_bit));
	endtask

	// result side: random stall before each beat, then pop until one is taken
	initial begin : rx_side
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_wait(rx_run, rx_calm);
			repeat (stall) @(negedge clk);
			pop = 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			check_beat();
			@(negedge clk);
			pop = 1'b0;
		end
	end

	initial begin : stimulus
		logic [7:0] strm[$];
		int         items;
		int         kind;
		int         n;
		int         cut;

		dir_tab = '{
			// clean layer iii header at offset 0, then last byte after done
			'{8'hFF, 1'b0, 1'b0, NO_RESULT},
			'{8'hFB, 1'b0, 1'b0, NO_RESULT},
			'{8'h90, 1'b0, 1'b0, NO_RESULT},
			'{8'h64, 1'b0, 1'b1,
				{1'b1, 24'd0, 1'b1, 9'd128, BR_VALID, 16'd44100, 1'b0, 1'b0, 1'b1}},
			'{8'h00, 1'b1, 1'b0, NO_RESULT},
			// broken sync, then ff ff sync, header completed on the last byte
			'{8'h12, 1'b0, 1'b0, NO_RESULT},
			'{8'hFF, 1'b0, 1'b0, NO_RESULT},
			'{8'hE2, 1'b0, 1'b0, NO_RESULT},
			'{8'hFF, 1'b0, 1'b0, NO_RESULT},
			'{8'hFF, 1'b0, 1'b0, NO_RESULT},
			'{8'hE0, 1'b0, 1'b0, NO_RESULT},
			'{8'h0C, 1'b1, 1'b1,
				{1'b1, 24'd3, 1'b0, 9'd320, BR_VALID, 16'd44100, 1'b0, 1'b1, 1'b1}},
			// free format bitrate with reserved sample rate, not layer iii
			'{8'hFF, 1'b0, 1'b0, NO_RESULT},
			'{8'hF0, 1'b0, 1'b0, NO_RESULT},
			'{8'h0C, 1'b0, 1'b0, NO_RESULT},
			'{8'h00, 1'b0, 1'b1,
				{1'b1, 24'd0, 1'b0, 9'd0, BR_FREE, 16'd0, 1'b1, 1'b0, 1'b0}},
			'{8'h55, 1'b1, 1'b0, NO_RESULT},
			// bad bitrate index at 48 khz, ended on the header byte
			'{8'hFF, 1'b0, 1'b0, NO_RESULT},
			'{8'hFA, 1'b0, 1'b0, NO_RESULT},
			'{8'hF4, 1'b0, 1'b0, NO_RESULT},
			'{8'h08, 1'b1, 1'b1,
				{1'b1, 24'd0, 1'b1, 9'd0, BR_BAD, 16'd48000, 1'b0, 1'b1, 1'b0}},
			// streams ending mid-capture and mid-hunt: not-found beats
			'{8'hFF, 1'b0, 1'b0, NO_RESULT},
			'{8'hFA, 1'b0, 1'b0, NO_RESULT},
			'{8'h12, 1'b1, 1'b1, NO_RESULT},
			'{8'hFF, 1'b1, 1'b1, NO_RESULT}
		};

		clear_scan();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_byte(dir_tab[i].b, dir_tab[i].lst, dir_tab[i].typed, dir_tab[i].want);

		// random streams: mostly well-formed headers with random content,
		// some cut short, some pure noise
		items = 0;
		while (items < RANDOM_ITEMS) begin
			strm.delete();
			kind = $urandom_range(0, 19);
			if (kind < 14) begin
				n = $urandom_range(0, 5);
				repeat (n) strm.push_back(noise_byte());
				strm.push_back(SYNC_BYTE);
				if ($urandom_range(0, 1) == 1)
					strm.push_back({SYNC_NIBBLE, 3'b101, 1'($urandom)});
				else
					strm.push_back({SYNC_NIBBLE, 4'($urandom)});
				strm.push_back(8'($urandom));
				strm.push_back(8'($urandom));
				n = $urandom_range(0, 4);
				repeat (n) strm.push_back(noise_byte());
			end else if (kind < 17) begin
				n = $urandom_range(0, 4);
				repeat (n) strm.push_back(noise_byte());
				cut = $urandom_range(1, 3);
				strm.push_back(SYNC_BYTE);
				if (cut > 1)
					strm.push_back({SYNC_NIBBLE, 4'($urandom)});
				if (cut > 2)
					strm.push_back(8'($urandom));
			end else begin
				n = $urandom_range(1, 8);
				repeat (n) strm.push_back(noise_byte());
			end
			foreach (strm[i])
				send_byte(strm[i], (i == strm.size() - 1), 1'b0, NO_RESULT);
			items += strm.size();
		end

		// drain, then leave room for a stray beat to show up
		wait (pending_results.size() == 0);
		repeat (24) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> filelist.f
sv/mfhs_pkg.sv
sv/mfhs_front.sv
sv/mfhs_queue.sv
sv/mfhs_back.sv
sv/mp3_frame_header_scanner.sv
test/tb_top.sv
